>>> hw/rtl/pmi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pmi_pkg;

  localparam int ENTRY_W = 21;
  localparam int DISP_W = 32;
  localparam int REG_W = 63;
  localparam int EXT_W = 9;
  localparam int IDX_W = 4;
  localparam int SQ_W = 64;
  localparam int FRAC_W = 36;
  localparam int MAX_EXTENT_DEF = 4;
  localparam int QUEUE_DEPTH = 2;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_CELL_X = 4'd0;
  localparam logic [IDX_W-1:0] REG_CELL_Y = 4'd1;
  localparam logic [IDX_W-1:0] REG_CELL_Z = 4'd2;
  localparam logic [IDX_W-1:0] REG_INV_X = 4'd3;
  localparam logic [IDX_W-1:0] REG_INV_Y = 4'd4;
  localparam logic [IDX_W-1:0] REG_INV_Z = 4'd5;
  localparam logic [IDX_W-1:0] REG_EXTENTS = 4'd6;
  localparam logic [IDX_W-1:0] REG_LIMIT = 4'd7;

  // one classified item handed from front to back
  typedef struct packed {
    logic signed [DISP_W-1:0] dx;
    logic signed [DISP_W-1:0] dy;
    logic signed [DISP_W-1:0] dz;
    logic [SQ_W-1:0] best;
    logic search;
  } pmi_job_t;

  // queue status seen by one side
  typedef struct packed {
    logic full;
    logic empty;
  } pmi_qstat_t;

  // cell geometry used by the back end
  typedef struct packed {
    logic [2:0][REG_W-1:0] lattice;
    logic [2:0][REG_W-1:0] inv;
    logic [EXT_W-1:0] ext;
  } pmi_geom_t;

  // signed matrix entry of a packed row
  function automatic logic signed [ENTRY_W-1:0] entry(input logic [REG_W-1:0] row,
                                                      input logic [1:0] col);
    return $signed(row[ENTRY_W*col +: ENTRY_W]);
  endfunction

  // saturating sum of three squares
  function automatic logic [SQ_W-1:0] sq_sum3(input logic [SQ_W-1:0] s0,
                                              input logic [SQ_W-1:0] s1,
                                              input logic [SQ_W-1:0] s2,
                                              input logic o0, input logic o1,
                                              input logic o2);
    logic [SQ_W+1:0] sum;
    sum = (SQ_W+2)'(s0) + (SQ_W+2)'(s1) + (SQ_W+2)'(s2);
    if (o0 || o1 || o2 || (sum[SQ_W+1:SQ_W] != 2'b00)) begin
      return '1;
    end
    return sum[SQ_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pmi_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pmi_disp_if;
  logic valid;
  logic ready;
  logic signed [31:0] disp_x;
  logic signed [31:0] disp_y;
  logic signed [31:0] disp_z;
  modport source(output valid, output disp_x, output disp_y, output disp_z, input ready);
  modport sink(input valid, input disp_x, input disp_y, input disp_z, output ready);
endinterface

interface pmi_image_if;
  logic valid;
  logic ready;
  logic signed [31:0] image_x;
  logic signed [31:0] image_y;
  logic signed [31:0] image_z;
  modport source(output valid, output image_x, output image_y, output image_z, input ready);
  modport sink(input valid, input image_x, input image_y, input image_z, output ready);
endinterface

interface pmi_cfg_if;
  logic valid;
  logic ready;
  logic [3:0] index;
  logic [62:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pmi_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pmi_front import pmi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  pmi_disp_if.sink disp,
  input  wire logic [REG_W-1:0] direct_limit_sq,
  input  wire pmi_qstat_t qstat,
  output logic push,
  output pmi_job_t job
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ = 2'd1;
  localparam logic [1:0] ST_SUM = 2'd2;

  logic [1:0] state;
  logic signed [DISP_W-1:0] d [3];
  logic [SQ_W-1:0] sq [3];
  logic ovf [3];
  logic [DISP_W:0] mag [3];
  logic [SQ_W-1:0] best;

  assign disp.ready = (state == ST_IDLE);

  // magnitudes of the input components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i][DISP_W-1] ? (DISP_W+1)'(-{d[i][DISP_W-1], d[i]})
                              : (DISP_W+1)'({1'b0, d[i]});
    end
  end

  assign best = sq_sum3(sq[0], sq[1], sq[2], ovf[0], ovf[1], ovf[2]);
  assign push = (state == ST_SUM) && !qstat.full;

  always_comb begin
    job.dx = d[0];
    job.dy = d[1];
    job.dz = d[2];
    job.best = best;
    job.search = best > {1'b0, direct_limit_sq};
  end

  // capture, square, classify
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (disp.valid) begin
            state <= ST_SQ;
          end
        end
        ST_SQ: state <= ST_SUM;
        ST_SUM: begin
          if (!qstat.full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && disp.valid) begin
      d[0] <= disp.disp_x;
      d[1] <= disp.disp_y;
      d[2] <= disp.disp_z;
    end
    if (state == ST_SQ) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SQ_W'(mag[i][DISP_W-1:0]) * SQ_W'(mag[i][DISP_W-1:0]);
        ovf[i] <= mag[i][DISP_W];
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pmi_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pmi_queue import pmi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire pmi_job_t wr_job,
  input  wire logic pop,
  output pmi_job_t rd_job,
  output pmi_qstat_t qstat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pmi_job_t mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full = (count == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_job = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pmi_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pmi_back import pmi_pkg::*; #(
  parameter int MAX_EXTENT = MAX_EXTENT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire pmi_geom_t geom,
  input  wire pmi_qstat_t qstat,
  input  wire pmi_job_t job,
  output logic pop,
  pmi_image_if.source image
);

  localparam int TW = $clog2(MAX_EXTENT + 1) + 1;
  localparam int AW = ENTRY_W + TW + 2;
  localparam int CW = ((AW + 6 > DISP_W) ? AW + 6 : DISP_W) + 1;
  localparam int FP_W = ENTRY_W + DISP_W;
  localparam int CP_W = ENTRY_W + FRAC_W;
  localparam int CS_W = CP_W + 2;
  localparam logic signed [CW-1:0] MAXV = CW'(64'sd2147483647);
  localparam logic signed [CW-1:0] MINV = -MAXV - CW'(1);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_FMUL = 3'd1;
  localparam logic [2:0] B_FSUM = 3'd2;
  localparam logic [2:0] B_CMUL = 3'd3;
  localparam logic [2:0] B_CSUM = 3'd4;
  localparam logic [2:0] B_SCAN = 3'd5;
  localparam logic [2:0] B_DRAIN = 3'd6;
  localparam logic [2:0] B_OUT = 3'd7;

  logic [2:0] state;
  logic [1:0] idx;
  logic signed [DISP_W-1:0] d [3];
  logic [SQ_W-1:0] best;
  logic search;
  logic signed [CP_W-1:0] prod [3];
  logic signed [FRAC_W-1:0] r [3];
  logic signed [CW-1:0] res [3];
  logic signed [FP_W-1:0] fp [3];
  logic signed [CP_W-1:0] cp [3];
  logic signed [FRAC_W-1:0] fsum;
  logic signed [CS_W-1:0] csum;
  logic signed [TW-1:0] ext [3];
  logic signed [TW-1:0] tt [3];
  logic signed [TW-1:0] ext_n [3];
  logic signed [AW-1:0] acc [3];
  logic signed [CW-1:0] cand [3];
  logic signed [CW-1:0] c1 [3];
  logic signed [CW-1:0] c2 [3];
  logic [CW-1:0] ab [3];
  logic [SQ_W-1:0] sq [3];
  logic ovf [3];
  logic v1;
  logic v2;
  logic [SQ_W-1:0] q;
  logic last;
  logic load_out;

  function automatic logic signed [DISP_W-1:0] sat32(input logic signed [CW-1:0] v);
    if (v > MAXV) begin
      return DISP_W'(MAXV);
    end
    if (v < MINV) begin
      return DISP_W'(MINV);
    end
    return DISP_W'(v);
  endfunction

  assign pop = (state == B_IDLE) && !qstat.empty;

  // wrap products for the current row
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      fp[j] = FP_W'(entry(geom.inv[idx], 2'(j))) * FP_W'(d[j]);
      cp[j] = CP_W'(entry(geom.lattice[idx], 2'(j))) * CP_W'(r[j]);
    end
    fsum = FRAC_W'(prod[0]) + FRAC_W'(prod[1]) + FRAC_W'(prod[2]);
    csum = CS_W'(prod[0]) + CS_W'(prod[1]) + CS_W'(prod[2]) + (CS_W'(1) <<< 29);
  end

  // clamped extents
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (int'(geom.ext[3*i +: 3]) > MAX_EXTENT) begin
        ext_n[i] = TW'(MAX_EXTENT);
      end else begin
        ext_n[i] = TW'(geom.ext[3*i +: 3]);
      end
    end
  end

  // candidate image for the current translation
  always_comb begin
    for (int m = 0; m < 3; m++) begin
      acc[m] = AW'(entry(geom.lattice[m], 2'd0)) * AW'(tt[0])
             + AW'(entry(geom.lattice[m], 2'd1)) * AW'(tt[1])
             + AW'(entry(geom.lattice[m], 2'd2)) * AW'(tt[2]);
      cand[m] = CW'(d[m]) - (CW'(acc[m]) <<< 6);
      ab[m] = c1[m][CW-1] ? CW'(-c1[m]) : CW'(c1[m]);
    end
    q = sq_sum3(sq[0], sq[1], sq[2], ovf[0], ovf[1], ovf[2]);
  end

  assign last = (tt[0] == ext[0]) && (tt[1] == ext[1]) && (tt[2] == ext[2]);
  assign load_out = (state == B_OUT) && (!image.valid || image.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      image.valid <= 1'b0;
    end else begin
      v1 <= (state == B_SCAN) && !((tt[0] == '0) && (tt[1] == '0) && (tt[2] == '0));
      v2 <= v1;
      if (load_out) begin
        image.valid <= 1'b1;
      end else if (image.ready) begin
        image.valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!qstat.empty) begin
            idx <= '0;
            state <= B_FMUL;
          end
        end
        B_FMUL: state <= B_FSUM;
        B_FSUM: begin
          if (idx == 2'd2) begin
            idx <= '0;
            state <= B_CMUL;
          end else begin
            idx <= idx + 1'b1;
            state <= B_FMUL;
          end
        end
        B_CMUL: state <= B_CSUM;
        B_CSUM: begin
          if (idx == 2'd2) begin
            idx <= '0;
            state <= search ? B_SCAN : B_OUT;
          end else begin
            idx <= idx + 1'b1;
            state <= B_CMUL;
          end
        end
        B_SCAN: begin
          if (last) begin
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (!v1 && !v2) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (load_out) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      d[0] <= job.dx;
      d[1] <= job.dy;
      d[2] <= job.dz;
      best <= job.best;
      search <= job.search;
    end
    if (state == B_FMUL) begin
      for (int j = 0; j < 3; j++) begin
        prod[j] <= CP_W'(fp[j]);
      end
    end
    if (state == B_CMUL) begin
      for (int j = 0; j < 3; j++) begin
        prod[j] <= cp[j];
      end
    end
    if (state == B_FSUM) begin
      r[idx] <= fsum;
    end
    if (state == B_CSUM) begin
      res[idx] <= CW'($signed(csum[CS_W-1:30]));
      if (idx == 2'd2) begin
        for (int i = 0; i < 3; i++) begin
          ext[i] <= ext_n[i];
          tt[i] <= -ext_n[i];
        end
      end
    end
    // translation counter, z innermost
    if (state == B_SCAN && !last) begin
      if (tt[2] == ext[2]) begin
        tt[2] <= -ext[2];
        if (tt[1] == ext[1]) begin
          tt[1] <= -ext[1];
          tt[0] <= tt[0] + TW'(1);
        end else begin
          tt[1] <= tt[1] + TW'(1);
        end
      end else begin
        tt[2] <= tt[2] + TW'(1);
      end
    end
    // candidate pipeline
    for (int m = 0; m < 3; m++) begin
      c1[m] <= cand[m];
      c2[m] <= c1[m];
      sq[m] <= SQ_W'(ab[m][DISP_W-1:0]) * SQ_W'(ab[m][DISP_W-1:0]);
      ovf[m] <= |ab[m][CW-1:DISP_W];
    end
    if (v2 && (q < best)) begin
      best <= q;
      for (int m = 0; m < 3; m++) begin
        res[m] <= c2[m];
      end
    end
    if (load_out) begin
      image.image_x <= sat32(res[0]);
      image.image_y <= sat32(res[1]);
      image.image_z <= sat32(res[2]);
    end
  end

  // best length only shrinks while searching
  a_best_mono: assert property (@(posedge clk) disable iff (rst)
    (state == B_DRAIN && $past(state) == B_SCAN) |-> best <= $past(best))
    else $error("best length grew during search");

  // a result appears only from the output step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(image.valid) |-> $past(state) == B_OUT)
    else $error("result raised outside output step");

  // no candidate left in flight when the result is formed
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT) |-> (!v1 && !v2))
    else $error("result formed with candidates in flight");

endmodule
`default_nettype wire

>>> hw/rtl/periodic_minimum_image_top.sv
// each item is wrapped into the cell; when its squared length exceeds the limit a lattice search
// then visits N = (2ex+1)(2ey+1)(2ez+1) translations, one per cycle
// the back end works on one item at a time and sets the throughput
// front end holds one item and a two-entry queue buffers classified items
// reset (synchronous, active high) clears registers to zero and the limit to all ones
`timescale 1ns / 1ps
`default_nettype none
module periodic_minimum_image_top import pmi_pkg::*; #(
  parameter int MAX_EXTENT = MAX_EXTENT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  pmi_disp_if.sink disp,
  pmi_image_if.source image,
  pmi_cfg_if.sink cfg
);

  pmi_geom_t geom;
  logic [REG_W-1:0] direct_limit_sq;
  pmi_qstat_t qstat;
  pmi_job_t push_job;
  pmi_job_t pop_job;
  logic push;
  logic pop;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      geom <= '0;
      direct_limit_sq <= '1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CELL_X: geom.lattice[0] <= cfg.data;
        REG_CELL_Y: geom.lattice[1] <= cfg.data;
        REG_CELL_Z: geom.lattice[2] <= cfg.data;
        REG_INV_X: geom.inv[0] <= cfg.data;
        REG_INV_Y: geom.inv[1] <= cfg.data;
        REG_INV_Z: geom.inv[2] <= cfg.data;
        REG_EXTENTS: geom.ext <= cfg.data[EXT_W-1:0];
        REG_LIMIT: direct_limit_sq <= cfg.data;
        default: ;
      endcase
    end
  end

  pmi_front u_front (
    .clk(clk),
    .rst(rst),
    .disp(disp),
    .direct_limit_sq(direct_limit_sq),
    .qstat(qstat),
    .push(push),
    .job(push_job)
  );

  pmi_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_job(push_job),
    .pop(pop),
    .rd_job(pop_job),
    .qstat(qstat)
  );

  pmi_back #(.MAX_EXTENT(MAX_EXTENT)) u_back (
    .clk(clk),
    .rst(rst),
    .geom(geom),
    .qstat(qstat),
    .job(pop_job),
    .pop(pop),
    .image(image)
  );

endmodule
`default_nettype wire

>>> tb/periodic_minimum_image_top_test.sv
`timescale 1ns / 1ps
module periodic_minimum_image_top_test import pmi_pkg::*;;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  logic clk;
  logic rst;

  pmi_disp_if disp_ch();
  pmi_image_if image_ch();
  pmi_cfg_if cfg_ch();

  periodic_minimum_image_top i_dut (
    .clk(clk),
    .rst(rst),
    .disp(disp_ch.sink),
    .image(image_ch.source),
    .cfg(cfg_ch.sink)
  );

  // shadow of the geometry registers
  logic [REG_W-1:0] cell_row [3];
  logic [REG_W-1:0] inv_row [3];
  logic [EXT_W-1:0] extents;
  logic [REG_W-1:0] limit_sq;

  vec_t pending_disp[$];
  vec_t expected_images[$];
  int failures;
  longint cycle_count;
  bit hold_active;
  bit hold_done;
  int hold_left;

  // append one displacement to the pending list
  task automatic queue_item(input vec_t v);
    pending_disp.insert(pending_disp.size(), v);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // matrix entry (r,c) as a signed 64-bit value
  function automatic longint mat_entry(input logic [REG_W-1:0] row, input int col);
    logic signed [20:0] e;
    e = row[21*col +: 21];
    return longint'(e);
  endfunction

  function automatic longint floor_div(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic [63:0] length_sq(input longint c [3]);
    logic [64:0] sum;
    logic [63:0] a;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      a = c[i] < 0 ? 64'(-c[i]) : 64'(c[i]);
      if (a > 64'hFFFF_FFFF) return '1;
      sum = sum + 65'(a * a);
      if (sum[64]) return '1;
    end
    return sum[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // shortest periodic image of one displacement
  function automatic vec_t minimum_image(input vec_t dv);
    longint d [3];
    longint r [3];
    longint res [3];
    longint c [3];
    longint f, n, acc;
    logic [63:0] best, q;
    int e [3];
    vec_t o;
    d[0] = longint'(dv.x); d[1] = longint'(dv.y); d[2] = longint'(dv.z);
    for (int i = 0; i < 3; i++) begin
      f = 0;
      for (int j = 0; j < 3; j++) f += mat_entry(inv_row[i], j) * d[j];
      n = floor_div(f + (64'sd1 <<< 35), 36);
      r[i] = f - n * (64'sd1 <<< 36);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += mat_entry(cell_row[i], j) * r[j];
      res[i] = floor_div(acc + (64'sd1 <<< 29), 30);
    end
    best = length_sq(d);
    if (best > {1'b0, limit_sq}) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = int'(extents[3*i +: 3]);
        if (e[i] > MAX_EXTENT_DEF) e[i] = MAX_EXTENT_DEF;
      end
      for (int a = -e[0]; a <= e[0]; a++)
        for (int b = -e[1]; b <= e[1]; b++)
          for (int k = -e[2]; k <= e[2]; k++) begin
            if (a == 0 && b == 0 && k == 0) continue;
            for (int m = 0; m < 3; m++) begin
              acc = mat_entry(cell_row[m], 0) * a + mat_entry(cell_row[m], 1) * b
                  + mat_entry(cell_row[m], 2) * k;
              c[m] = d[m] - acc * 64;
            end
            q = length_sq(c);
            if (q < best) begin
              best = q;
              res = c;
            end
          end
    end
    o.x = clamp32(res[0]);
    o.y = clamp32(res[1]);
    o.z = clamp32(res[2]);
    return o;
  endfunction

  // displacement driver with random gaps
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      disp_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (disp_ch.valid && disp_ch.ready) begin
        expected_images.insert(expected_images.size(),
                               minimum_image('{disp_ch.disp_x, disp_ch.disp_y,
                                               disp_ch.disp_z}));
      end
      if (!disp_ch.valid || disp_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          disp_ch.valid <= 1'b0;
        end else if (pending_disp.size() > 0) begin
          vec_t v;
          v = pending_disp.pop_front();
          disp_ch.disp_x <= v.x;
          disp_ch.disp_y <= v.y;
          disp_ch.disp_z <= v.z;
          disp_ch.valid <= 1'b1;
          send_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                      (($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 4));
        end else begin
          disp_ch.valid <= 1'b0;
        end
      end
    end
  end

  // image monitor with random back pressure
  always @(posedge clk) begin
    if (rst) begin
      image_ch.ready <= 1'b0;
    end else begin
      if (image_ch.valid && image_ch.ready) begin
        if (expected_images.size() == 0) begin
          $error("image transfer with nothing expected");
          failures++;
        end else begin
          vec_t ev;
          ev = expected_images.pop_front();
          if (image_ch.image_x !== ev.x) begin
            $error("image_x expected %0d actual %0d", ev.x, image_ch.image_x);
            failures++;
          end
          if (image_ch.image_y !== ev.y) begin
            $error("image_y expected %0d actual %0d", ev.y, image_ch.image_y);
            failures++;
          end
          if (image_ch.image_z !== ev.z) begin
            $error("image_z expected %0d actual %0d", ev.z, image_ch.image_z);
            failures++;
          end
        end
      end
      if (hold_active) begin
        image_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 29) == 0) begin
        image_ch.ready <= 1'b0;
      end else begin
        image_ch.ready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  // long receiver hold-off, counted in cycles, once a large batch is waiting
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_active <= 1'b0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      hold_active <= (hold_left > 1);
    end else if (!hold_done && pending_disp.size() > 150) begin
      hold_left <= 600;
      hold_active <= 1'b1;
      hold_done <= 1'b1;
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("periodic_minimum_image_top: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_CELL_X: cell_row[0] = val;
      REG_CELL_Y: cell_row[1] = val;
      REG_CELL_Z: cell_row[2] = val;
      REG_INV_X: inv_row[0] = val;
      REG_INV_Y: inv_row[1] = val;
      REG_INV_Z: inv_row[2] = val;
      REG_EXTENTS: extents = val[EXT_W-1:0];
      REG_LIMIT: limit_sq = val;
      default: ;
    endcase
  endtask

  function automatic logic [REG_W-1:0] pack_row(input int a, input int b, input int c);
    logic [20:0] ea, eb, ec;
    ea = 21'(a); eb = 21'(b); ec = 21'(c);
    return {ec, eb, ea};
  endfunction

  // load a diagonal-ish cell (Q11.10) and its inverse (Q1.20)
  task automatic load_cell(input int lx, input int ly, input int lz, input int skew);
    write_reg(REG_CELL_X, pack_row(lx * 1024, skew, 0));
    write_reg(REG_CELL_Y, pack_row(0, ly * 1024, 0));
    write_reg(REG_CELL_Z, pack_row(0, 0, lz * 1024));
    write_reg(REG_INV_X, pack_row((1 << 20) / lx, 0, 0));
    write_reg(REG_INV_Y, pack_row(0, (1 << 20) / ly, 0));
    write_reg(REG_INV_Z, pack_row(0, 0, (1 << 20) / lz));
  endtask

  task automatic drain();
    while (pending_disp.size() > 0 || disp_ch.valid || expected_images.size() > 0)
      @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_comp(input int scale);
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $urandom;
      default: return $signed($urandom_range(0, 2 * scale)) - scale;
    endcase
  endfunction

  task automatic random_items(input int count, input int scale);
    for (int i = 0; i < count; i++)
      queue_item('{rand_comp(scale), rand_comp(scale), rand_comp(scale)});
  endtask

  initial begin
    failures = 0;
    cycle_count = 0;
    rst = 1'b1;
    disp_ch.valid = 1'b0;
    disp_ch.disp_x = '0;
    disp_ch.disp_y = '0;
    disp_ch.disp_z = '0;
    image_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    for (int i = 0; i < 3; i++) begin
      cell_row[i] = '0;
      inv_row[i] = '0;
    end
    extents = '0;
    limit_sq = '1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // all-zero registers: wrapped result is zero
    queue_item('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0});
    queue_item('{32'sd1, -32'sd1, 32'sh1234_5678});
    drain();

    // wrap only, then search with small and clamped extents
    load_cell(10, 12, 9, 300);
    write_reg(REG_EXTENTS, REG_W'(9'b001_001_001));
    queue_item('{32'sd0, 32'sd0, 32'sd0});
    queue_item('{32'sd5 <<< 16, 32'sd6 <<< 16, 32'sd4 <<< 16});
    queue_item('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    queue_item('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    drain();
    write_reg(REG_LIMIT, '0);
    queue_item('{32'sd0, 32'sd0, 32'sd0});
    queue_item('{32'sd5 <<< 16, 32'sd0, 32'sd0});
    queue_item('{32'sd15 <<< 16, -32'sd13 <<< 16, 32'sd20 <<< 16});
    queue_item('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1});
    drain();
    write_reg(REG_EXTENTS, '1);
    write_reg(4'd9, '1);
    queue_item('{32'sd40 <<< 16, 32'sd0, -32'sd40 <<< 16});
    queue_item('{32'sh7FFF_FFFF, 32'sd0, 32'sd0});
    drain();

    // random phases across several settings
    write_reg(REG_EXTENTS, REG_W'(9'b000_001_001));
    write_reg(REG_LIMIT, 63'd1 << 36);
    random_items(250, 60 << 16);
    drain();
    load_cell(1000, 1, 1023, -1048576);
    write_reg(REG_EXTENTS, REG_W'(9'b010_000_001));
    write_reg(REG_LIMIT, '0);
    random_items(200, 1 << 30);
    drain();
    write_reg(REG_CELL_X, REG_W'({$urandom, $urandom}));
    write_reg(REG_INV_Y, REG_W'({$urandom, $urandom}));
    write_reg(REG_LIMIT, REG_W'({$urandom, $urandom}));
    write_reg(REG_EXTENTS, REG_W'(9'b001_000_000));
    random_items(250, 1 << 24);
    drain();

    if (failures == 0) begin
      $display("periodic_minimum_image_top: match");
    end else begin
      $display("periodic_minimum_image_top: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pmi_pkg.sv
hw/rtl/pmi_if.sv
hw/rtl/pmi_front.sv
hw/rtl/pmi_queue.sv
hw/rtl/pmi_back.sv
hw/rtl/periodic_minimum_image_top.sv
tb/periodic_minimum_image_top_test.sv
